### rtl/core/source_text_tokenizer_core_assert.svh
// Assertion macros for the tokenizer core RTL, included by stt_queue.
// Depends on i_clk and i_rst_n being present in the including module.
`ifndef SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define STT_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// next-cycle implication, checked outside reset
`define STT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

### rtl/core/stt_pkg.sv
// Types, constants and byte classifiers for the source text tokenizer core.
// No dependencies.
package stt_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int OUT_W       = 16;
    localparam int EXT_W       = (OFFSET_BITS > OUT_W) ? OFFSET_BITS : OUT_W;
    localparam int QIDX_W      = 2;
    localparam int QDEPTH      = 1 << QIDX_W;

    localparam logic [OFFSET_BITS-1:0] POS_MAX  = '1;
    localparam logic [OUT_W-1:0]       OUT_CAP  = '1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [3:0] KIND_END    = 4'd0;
    localparam logic [3:0] KIND_NAME   = 4'd1;
    localparam logic [3:0] KIND_NUMBER = 4'd2;
    localparam logic [3:0] KIND_STRING = 4'd3;
    localparam logic [3:0] KIND_LT     = 4'd4;
    localparam logic [3:0] KIND_GT     = 4'd5;
    localparam logic [3:0] KIND_ASSIGN = 4'd6;
    localparam logic [3:0] KIND_LE     = 4'd7;
    localparam logic [3:0] KIND_GE     = 4'd8;
    localparam logic [3:0] KIND_EQUAL  = 4'd9;
    localparam logic [3:0] KIND_SINGLE = 4'd10;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SPACE,
        MODE_NUMBER,
        MODE_NAME,
        MODE_STRING,
        MODE_COMPARE
    } t_mode;

    typedef enum logic [1:0] {
        CMP_NONE,
        CMP_LT,
        CMP_GT,
        CMP_EQ
    } t_cmp;

    typedef struct packed {
        logic [3:0]       token_kind;
        logic [7:0]       char_code;
        logic [OUT_W-1:0] start_offset;
        logic [OUT_W-1:0] token_length;
        logic [OUT_W-1:0] line_number;
        logic             newline_in_string;
        logic             unterminated_string;
    } t_token;

    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_space_start(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_NL) || (b == CH_CR) || (b == CH_TAB) ||
               (b == CH_VT);
    endfunction

    function automatic logic is_space_any(input logic [7:0] b);
        return is_space_start(b) || (b == CH_FF);
    endfunction

    function automatic logic [OUT_W-1:0] cap_out(input logic [OFFSET_BITS-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (ext > EXT_W'(OUT_CAP)) begin
            return OUT_CAP;
        end
        return ext[OUT_W-1:0];
    endfunction

endpackage

### rtl/core/source_text_tokenizer_core.sv
// Streaming source text tokenizer: one byte in per cycle, one token out per cycle while i_out_ready holds.
// The scanner takes a byte every cycle while its four-entry token queue has room;
// a byte that closes a token and also forms a single-character or end token gives
// two results, and the output register drains them one per cycle, so a long run
// of such bytes is limited by the output side. A token closed by a byte is written
// into the queue and then loaded into the output register. Byte 0 ends the
// source, emits an end token and restarts the position at zero. No reset sweep.
module source_text_tokenizer_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_byte_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [3:0]                o_token_kind,
    output logic [7:0]                o_char_code,
    output logic [stt_pkg::OUT_W-1:0] o_start_offset,
    output logic [stt_pkg::OUT_W-1:0] o_token_length,
    output logic [stt_pkg::OUT_W-1:0] o_line_number,
    output logic                      o_newline_in_string,
    output logic                      o_unterminated_string,
    output logic                      o_last_of_run
);
    import stt_pkg::*;

    logic   push, pop;
    t_entry entry, head;
    t_qstat qstat;

    stt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_byte_value (i_byte_value),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_entry      (entry)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    stt_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_head                (head),
        .i_qstat               (qstat),
        .o_pop                 (pop),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_token_kind          (o_token_kind),
        .o_char_code           (o_char_code),
        .o_start_offset        (o_start_offset),
        .o_token_length        (o_token_length),
        .o_line_number         (o_line_number),
        .o_newline_in_string   (o_newline_in_string),
        .o_unterminated_string (o_unterminated_string),
        .o_last_of_run         (o_last_of_run)
    );

endmodule

### rtl/core/stt_front.sv
// Scanner front end: takes source bytes, tracks token state and position,
// and pushes the zero, one or two tokens each byte closes. Uses stt_pkg.
module stt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_byte_value,
    input  stt_pkg::t_qstat i_qstat,
    output logic           o_push,
    output stt_pkg::t_entry o_entry
);
    import stt_pkg::*;

    t_mode                  r_mode, n_mode;
    t_cmp                   r_pending, n_pending;
    logic [OFFSET_BITS-1:0] r_token_start, n_token_start;
    logic [OFFSET_BITS-1:0] r_position, n_position;
    logic [OUT_W-1:0]       r_line, n_line;
    logic                   r_str_nl, n_str_nl;

    logic                   take;
    logic [7:0]             b;
    logic                   is_end, b_digit, b_letter, b_cmp, b_single;
    logic                   restart;
    logic [OFFSET_BITS-1:0] cur_len, pos_inc, close_len;
    logic [OUT_W-1:0]       line_inc;
    logic                   has_a, has_b;
    t_token                 tok_a, tok_b;

    assign b          = i_byte_value;
    assign o_in_ready = !i_qstat.full;
    assign take       = i_in_valid && o_in_ready;
    assign is_end     = (b == CH_NUL);
    assign b_digit    = is_digit(b);
    assign b_letter   = is_letter(b);
    assign b_cmp      = (b == CH_LT) || (b == CH_GT) || (b == CH_EQ);
    assign b_single   = !is_end && !b_digit && !b_letter && (b != CH_QUOTE) && !b_cmp &&
                        !is_space_start(b);
    assign cur_len    = (r_token_start > r_position) ? '0 : (r_position - r_token_start);
    assign pos_inc    = (r_position != POS_MAX) ? (r_position + 1'b1) : r_position;
    assign close_len  = pos_inc - r_token_start;
    assign line_inc   = (r_line != OUT_CAP) ? (r_line + 1'b1) : r_line;

    always_comb begin
        unique case (r_mode)
            MODE_SPACE:   restart = !is_space_any(b);
            MODE_NUMBER:  restart = !b_digit;
            MODE_NAME:    restart = !(b_letter || b_digit || (b == CH_UNDER));
            MODE_STRING:  restart = is_end;
            MODE_COMPARE: restart = (b != CH_EQ);
            default:      restart = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_mode        = r_mode;
        n_pending     = r_pending;
        n_token_start = r_token_start;
        n_line        = r_line;
        n_str_nl      = r_str_nl;
        unique case (r_mode)
            MODE_SPACE: begin
                if (!restart && (b == CH_NL)) begin
                    n_line = line_inc;
                end
            end
            MODE_STRING: begin
                if (b == CH_QUOTE) begin
                    n_mode = MODE_IDLE;
                end else if (b == CH_NL) begin
                    n_str_nl = 1'b1;
                end
            end
            MODE_COMPARE: begin
                n_pending = CMP_NONE;
                if (!restart) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
            end
        endcase
        if (restart) begin
            n_mode = MODE_IDLE;
            if (b_digit) begin
                n_mode        = MODE_NUMBER;
                n_token_start = r_position;
            end else if (b_letter) begin
                n_mode        = MODE_NAME;
                n_token_start = r_position;
            end else if (b == CH_QUOTE) begin
                n_mode        = MODE_STRING;
                n_token_start = r_position;
                n_str_nl      = 1'b0;
            end else if (b_cmp) begin
                n_mode        = MODE_COMPARE;
                n_token_start = r_position;
                n_pending     = (b == CH_LT) ? CMP_LT : ((b == CH_GT) ? CMP_GT : CMP_EQ);
            end else if (is_space_start(b)) begin
                n_mode = MODE_SPACE;
                if (b == CH_NL) begin
                    n_line = line_inc;
                end
            end
        end
        if (is_end) begin
            n_mode     = MODE_IDLE;
            n_pending  = CMP_NONE;
            n_position = '0;
        end else begin
            n_position = pos_inc;
        end
    end

    // token outputs
    always_comb begin
        has_a = 1'b0;
        tok_a = '0;
        tok_a.start_offset = cap_out(r_token_start);
        tok_a.token_length = cap_out(cur_len);
        tok_a.line_number  = r_line;
        unique case (r_mode)
            MODE_NUMBER: begin
                has_a            = restart;
                tok_a.token_kind = KIND_NUMBER;
            end
            MODE_NAME: begin
                has_a            = restart;
                tok_a.token_kind = KIND_NAME;
            end
            MODE_STRING: begin
                has_a                     = is_end || (b == CH_QUOTE);
                tok_a.token_kind          = KIND_STRING;
                tok_a.token_length        = is_end ? cap_out(cur_len) : cap_out(close_len);
                tok_a.newline_in_string   = r_str_nl;
                tok_a.unterminated_string = is_end;
            end
            MODE_COMPARE: begin
                has_a              = 1'b1;
                tok_a.token_length = restart ? OUT_W'(1) : OUT_W'(2);
                unique case (r_pending)
                    CMP_GT:  tok_a.token_kind = restart ? KIND_GT : KIND_GE;
                    CMP_EQ:  tok_a.token_kind = restart ? KIND_ASSIGN : KIND_EQUAL;
                    default: tok_a.token_kind = restart ? KIND_LT : KIND_LE;
                endcase
            end
            default: begin
            end
        endcase

        has_b              = restart && (is_end || b_single);
        tok_b              = '0;
        tok_b.token_kind   = is_end ? KIND_END : KIND_SINGLE;
        tok_b.char_code    = is_end ? 8'h00 : b;
        tok_b.start_offset = cap_out(r_position);
        tok_b.token_length = is_end ? OUT_W'(0) : OUT_W'(1);
        tok_b.line_number  = r_line;

        o_entry.tok0 = has_a ? tok_a : tok_b;
        o_entry.tok1 = tok_b;
        o_entry.two  = has_a && has_b;
        o_push       = take && (has_a || has_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_pending     <= CMP_NONE;
            r_token_start <= '0;
            r_position    <= '0;
            r_line        <= '0;
            r_str_nl      <= 1'b0;
        end else if (take) begin
            r_mode        <= n_mode;
            r_pending     <= n_pending;
            r_token_start <= n_token_start;
            r_position    <= n_position;
            r_line        <= n_line;
            r_str_nl      <= n_str_nl;
        end
    end

endmodule

### rtl/core/stt_queue.sv
// Short queue of token entries between the scanner and the output stage.
// Uses stt_pkg and the tokenizer assertion macros.
module stt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stt_pkg::t_entry i_entry,
    input  logic            i_pop,
    output stt_pkg::t_entry o_head,
    output stt_pkg::t_qstat o_qstat
);
    import stt_pkg::*;

    `include "source_text_tokenizer_core_assert.svh"

    t_entry            r_mem [QDEPTH];
    logic [QIDX_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QIDX_W:0]   r_count, n_count;

    assign o_head        = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == (QIDX_W+1)'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    `STT_ASSERT_IMPLY(a_no_overflow, i_push, !o_qstat.full)
    `STT_ASSERT_IMPLY(a_no_underflow, i_pop, !o_qstat.empty)
    `STT_ASSERT_IMPLY(a_count_bound, 1'b1, r_count <= (QIDX_W+1)'(QDEPTH))
    `STT_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

### rtl/core/stt_back.sv
// Output stage: splits queue entries into single tokens and holds each in
// an output register until the transfer completes. Uses stt_pkg.
module stt_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  stt_pkg::t_entry            i_head,
    input  stt_pkg::t_qstat            i_qstat,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [3:0]                 o_token_kind,
    output logic [7:0]                 o_char_code,
    output logic [stt_pkg::OUT_W-1:0]  o_start_offset,
    output logic [stt_pkg::OUT_W-1:0]  o_token_length,
    output logic [stt_pkg::OUT_W-1:0]  o_line_number,
    output logic                       o_newline_in_string,
    output logic                       o_unterminated_string,
    output logic                       o_last_of_run
);
    import stt_pkg::*;

    logic   r_out_valid;
    logic   r_slot, n_slot;
    t_token r_tok;
    logic   r_last;
    logic   load, fetch, last_sel;
    t_token tok_sel;

    assign load     = !r_out_valid || i_out_ready;
    assign fetch    = load && !i_qstat.empty;
    assign tok_sel  = r_slot ? i_head.tok1 : i_head.tok0;
    assign last_sel = r_slot || !i_head.two;
    assign o_pop    = fetch && last_sel;
    assign n_slot   = fetch ? !last_sel : r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_slot      <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= !i_qstat.empty;
            end
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch) begin
            r_tok  <= tok_sel;
            r_last <= last_sel;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_token_kind          = r_tok.token_kind;
    assign o_char_code           = r_tok.char_code;
    assign o_start_offset        = r_tok.start_offset;
    assign o_token_length        = r_tok.token_length;
    assign o_line_number         = r_tok.line_number;
    assign o_newline_in_string   = r_tok.newline_in_string;
    assign o_unterminated_string = r_tok.unterminated_string;
    assign o_last_of_run         = r_last;

endmodule

### verif/tb_top.sv
// Self-checking bench for source_text_tokenizer_core: directed table and random sources.
// Predicts tokens in-bench and scoreboards every output transfer. Depends on rtl/core/stt_pkg.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int PW        = stt_pkg::OFFSET_BITS;
    localparam int N_DIR     = 24;
    localparam int N_RANDOM  = 1200;
    localparam int HOLD_FROM = 600;
    localparam int HOLD_LEN  = 400;

    localparam logic [PW-1:0] POS_TOP = '1;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  chr;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        nl;
        logic        unterm;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        tok_t       tok;
    } src_row_t;

    localparam tok_t NO_TOK = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_byte_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_token_kind;
    logic [7:0]  o_char_code;
    logic [15:0] o_start_offset;
    logic [15:0] o_token_length;
    logic [15:0] o_line_number;
    logic        o_newline_in_string;
    logic        o_unterminated_string;
    logic        o_last_of_run;

    source_text_tokenizer_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_byte_value          (i_byte_value),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_token_kind          (o_token_kind),
        .o_char_code           (o_char_code),
        .o_start_offset        (o_start_offset),
        .o_token_length        (o_token_length),
        .o_line_number         (o_line_number),
        .o_newline_in_string   (o_newline_in_string),
        .o_unterminated_string (o_unterminated_string),
        .o_last_of_run         (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // tokenizer state mirror
    t_mode         lex_mode = MODE_IDLE;
    t_cmp          lex_cmp = CMP_NONE;
    logic [PW-1:0] lex_tok_start = '0;
    logic [PW-1:0] lex_pos = '0;
    logic [15:0]   lex_line = '0;
    logic          lex_str_nl = 1'b0;
    tok_t          step_toks [2];
    int            step_n;

    src_row_t src_q [$];
    src_row_t dir_tab [N_DIR];
    src_row_t cur;
    tok_t     tokens_due [$];
    tok_t     want;
    int       n_total;
    int       n_taken = 0;
    int       n_out = 0;
    int       n_errors = 0;
    int       burst_left = 8;
    int       gap_left = 0;
    int       rx_cyc = 0;
    int       rx_rate = 0;
    int       rx_phase_left = 0;

    function automatic tok_t mk(logic [3:0] k, logic [7:0] c, logic [15:0] s, logic [15:0] l,
                                logic [15:0] ln, logic nl, logic un);
        mk = '{k, c, s, l, ln, nl, un, 1'b1};
    endfunction

    function automatic logic is_dec(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic opens_blank(logic [7:0] b);
        return b == CH_SPACE || b == CH_NL || b == CH_CR || b == CH_TAB || b == CH_VT;
    endfunction

    function automatic logic [7:0] rand_alpha();
        return ($urandom_range(0, 1) != 0) ? 8'(8'h41 + $urandom_range(0, 25))
                                           : 8'(8'h61 + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_NL;
            3: return CH_CR;
            4: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_v);
        if (got !== exp_v) begin
            report_mismatch($sformatf("token %0d %s: got %0h, want %0h", n_out, name, got, exp_v));
        end
    endtask

    task automatic bump_line();
        if (lex_line != 16'hFFFF) begin
            lex_line++;
        end
    endtask

    task automatic emit_tok(logic [3:0] kind, logic [7:0] ch, logic [PW-1:0] start,
                            logic [PW-1:0] len, logic nl, logic un);
        logic [31:0] s32;
        logic [31:0] l32;
        s32 = 32'(start);
        l32 = 32'(len);
        if (step_n < 2) begin
            step_toks[step_n] = '{kind, ch, (s32 > 32'hFFFF) ? 16'hFFFF : s32[15:0],
                                  (l32 > 32'hFFFF) ? 16'hFFFF : l32[15:0],
                                  lex_line, nl, un, 1'b0};
            step_n++;
        end
    endtask

    task automatic start_tok(logic [7:0] b);
        lex_mode = MODE_IDLE;
        if (b == CH_NUL) begin
            emit_tok(KIND_END, 8'h00, lex_pos, '0, 1'b0, 1'b0);
        end else if (is_dec(b)) begin
            lex_mode = MODE_NUMBER;
            lex_tok_start = lex_pos;
        end else if (is_alpha(b)) begin
            lex_mode = MODE_NAME;
            lex_tok_start = lex_pos;
        end else if (b == CH_QUOTE) begin
            lex_mode = MODE_STRING;
            lex_tok_start = lex_pos;
            lex_str_nl = 1'b0;
        end else if (b == CH_LT || b == CH_GT || b == CH_EQ) begin
            lex_mode = MODE_COMPARE;
            lex_tok_start = lex_pos;
            lex_cmp = (b == CH_LT) ? CMP_LT : (b == CH_GT) ? CMP_GT : CMP_EQ;
        end else if (opens_blank(b)) begin
            lex_mode = MODE_SPACE;
            if (b == CH_NL) begin
                bump_line();
            end
        end else begin
            emit_tok(KIND_SINGLE, b, lex_pos, PW'(1), 1'b0, 1'b0);
        end
    endtask

    // one source byte in, up to two tokens out in step_toks
    task automatic lex_byte(logic [7:0] b);
        logic [PW-1:0] len;
        logic [PW-1:0] fin;
        logic [3:0]    k_one;
        logic [3:0]    k_two;
        step_n = 0;
        len = (lex_tok_start > lex_pos) ? '0 : lex_pos - lex_tok_start;
        case (lex_mode)
            MODE_SPACE: begin
                if (opens_blank(b) || b == CH_FF) begin
                    if (b == CH_NL) begin
                        bump_line();
                    end
                end else begin
                    start_tok(b);
                end
            end
            MODE_NUMBER: begin
                if (!is_dec(b)) begin
                    emit_tok(KIND_NUMBER, 8'h00, lex_tok_start, len, 1'b0, 1'b0);
                    start_tok(b);
                end
            end
            MODE_NAME: begin
                if (!(is_alpha(b) || is_dec(b) || b == CH_UNDER)) begin
                    emit_tok(KIND_NAME, 8'h00, lex_tok_start, len, 1'b0, 1'b0);
                    start_tok(b);
                end
            end
            MODE_STRING: begin
                if (b == CH_NUL) begin
                    emit_tok(KIND_STRING, 8'h00, lex_tok_start, len, lex_str_nl, 1'b1);
                    start_tok(b);
                end else if (b == CH_QUOTE) begin
                    fin = (lex_pos < POS_TOP) ? lex_pos + 1'b1 : lex_pos;
                    emit_tok(KIND_STRING, 8'h00, lex_tok_start, fin - lex_tok_start,
                             lex_str_nl, 1'b0);
                    lex_mode = MODE_IDLE;
                end else if (b == CH_NL) begin
                    lex_str_nl = 1'b1;
                end
            end
            MODE_COMPARE: begin
                case (lex_cmp)
                    CMP_GT: begin
                        k_one = KIND_GT;
                        k_two = KIND_GE;
                    end
                    CMP_EQ: begin
                        k_one = KIND_ASSIGN;
                        k_two = KIND_EQUAL;
                    end
                    default: begin
                        k_one = KIND_LT;
                        k_two = KIND_LE;
                    end
                endcase
                if (b == CH_EQ) begin
                    emit_tok(k_two, 8'h00, lex_tok_start, PW'(2), 1'b0, 1'b0);
                    lex_mode = MODE_IDLE;
                end else begin
                    emit_tok(k_one, 8'h00, lex_tok_start, PW'(1), 1'b0, 1'b0);
                    start_tok(b);
                end
                if (lex_mode != MODE_COMPARE) begin
                    lex_cmp = CMP_NONE;
                end
            end
            default: begin
                start_tok(b);
            end
        endcase
        if (b == CH_NUL) begin
            lex_pos = '0;
            lex_mode = MODE_IDLE;
            lex_cmp = CMP_NONE;
        end else if (lex_pos < POS_TOP) begin
            lex_pos++;
        end
        if (step_n > 0) begin
            step_toks[step_n-1].last = 1'b1;
        end
    endtask

    task automatic add_byte(logic [7:0] b);
        src_q.push_back('{b, 1'b0, NO_TOK});
    endtask

    // mostly well-formed token sequences, always closed by end of source
    task automatic add_source();
        logic [7:0] b;
        int         ntok;
        ntok = $urandom_range(1, 12);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
            add_byte(CH_NUL);
            return;
        end
        for (int t = 0; t < ntok; t++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    add_byte(rand_alpha());
                    repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(0, 3))
                            0: add_byte(8'(8'h30 + $urandom_range(0, 9)));
                            1: add_byte(CH_UNDER);
                            default: add_byte(rand_alpha());
                        endcase
                    end
                end
                2, 3: begin
                    repeat ($urandom_range(1, 5)) add_byte(8'(8'h30 + $urandom_range(0, 9)));
                end
                4: begin
                    add_byte(CH_QUOTE);
                    repeat ($urandom_range(0, 6)) begin
                        b = ($urandom_range(0, 5) == 0) ? CH_NL : 8'($urandom_range(1, 255));
                        add_byte((b == CH_QUOTE) ? CH_SPACE : b);
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        add_byte(CH_NUL);
                        return;
                    end
                    add_byte(CH_QUOTE);
                end
                5: begin
                    case ($urandom_range(0, 2))
                        0: add_byte(CH_LT);
                        1: add_byte(CH_GT);
                        default: add_byte(CH_EQ);
                    endcase
                    if ($urandom_range(0, 1) != 0) begin
                        add_byte(CH_EQ);
                    end
                end
                6, 7: begin
                    repeat ($urandom_range(1, 4)) add_byte(rand_blank());
                end
                8: begin
                    add_byte(8'($urandom_range(1, 255)));
                end
                default: begin
                    add_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
        add_byte(CH_NUL);
    endtask

    // sender: bursts and gaps; prediction on every accepted transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                lex_byte(cur.b);
                if (cur.typed) begin
                    tokens_due.push_back(cur.tok);
                end else begin
                    for (int k = 0; k < step_n; k++) begin
                        tokens_due.push_back(step_toks[k]);
                    end
                end
                n_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (src_q.size() > 0) begin
                    cur = src_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_byte_value <= cur.b;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall rate changes by phase, with one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            rx_cyc++;
            if (rx_phase_left == 0) begin
                rx_rate = $urandom_range(0, 2);
                rx_phase_left = $urandom_range(32, 160);
            end else begin
                rx_phase_left--;
            end
            if (rx_cyc >= HOLD_FROM && rx_cyc < HOLD_FROM + HOLD_LEN) begin
                i_out_ready <= 1'b0;
            end else begin
                case (rx_rate)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tokens_due.size() == 0) begin
                report_mismatch($sformatf("token %0d arrived with none expected", n_out));
            end else begin
                want = tokens_due.pop_front();
                check_field("token_kind", 16'(o_token_kind), 16'(want.kind));
                check_field("char_code", 16'(o_char_code), 16'(want.chr));
                check_field("start_offset", o_start_offset, want.start);
                check_field("token_length", o_token_length, want.len);
                check_field("line_number", o_line_number, want.line);
                check_field("newline_in_string", 16'(o_newline_in_string), 16'(want.nl));
                check_field("unterminated_string", 16'(o_unterminated_string),
                            16'(want.unterm));
                check_field("last_of_run", 16'(o_last_of_run), 16'(want.last));
            end
            n_out++;
        end
    end

    initial begin
        dir_tab = '{
            '{CH_NUL,   1'b1, mk(KIND_END, 8'h00, 0, 0, 0, 1'b0, 1'b0)},
            '{"A",      1'b0, NO_TOK},
            '{CH_UNDER, 1'b0, NO_TOK},
            '{"9",      1'b0, NO_TOK},
            '{CH_LT,    1'b0, NO_TOK},
            '{CH_EQ,    1'b1, mk(KIND_LE, 8'h00, 3, 2, 0, 1'b0, 1'b0)},
            '{CH_GT,    1'b0, NO_TOK},
            '{CH_EQ,    1'b1, mk(KIND_GE, 8'h00, 5, 2, 0, 1'b0, 1'b0)},
            '{CH_EQ,    1'b0, NO_TOK},
            '{"x",      1'b0, NO_TOK},
            '{CH_EQ,    1'b0, NO_TOK},
            '{CH_EQ,    1'b1, mk(KIND_EQUAL, 8'h00, 9, 2, 0, 1'b0, 1'b0)},
            '{CH_GT,    1'b0, NO_TOK},
            '{CH_NL,    1'b0, NO_TOK},
            '{CH_FF,    1'b0, NO_TOK},
            '{CH_TAB,   1'b0, NO_TOK},
            '{"0",      1'b0, NO_TOK},
            '{8'hFF,    1'b0, NO_TOK},
            '{CH_FF,    1'b1, mk(KIND_SINGLE, CH_FF, 17, 1, 1, 1'b0, 1'b0)},
            '{CH_QUOTE, 1'b0, NO_TOK},
            '{CH_NL,    1'b0, NO_TOK},
            '{CH_QUOTE, 1'b1, mk(KIND_STRING, 8'h00, 18, 3, 1, 1'b1, 1'b0)},
            '{CH_QUOTE, 1'b0, NO_TOK},
            '{CH_NUL,   1'b0, NO_TOK}
        };
        for (int i = 0; i < N_DIR; i++) begin
            src_q.push_back(dir_tab[i]);
        end
        while (src_q.size() < N_DIR + N_RANDOM) begin
            add_source();
        end
        n_total = src_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_taken != n_total) @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tokens_due.size() != 0) begin
            report_mismatch($sformatf("%0d tokens never arrived", tokens_due.size()));
        end
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout after %0d of %0d bytes, %0d tokens", n_taken, n_total, n_out);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/stt_pkg.sv
rtl/core/stt_front.sv
rtl/core/stt_queue.sv
rtl/core/stt_back.sv
rtl/core/source_text_tokenizer_core.sv
verif/tb_top.sv
